FILE: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator: operation and
// status codes, controller states, datapath commands and status flags.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int REQ_W  = 6;
  localparam int PIDX_W = 10;
  localparam int ORD_W  = 4;
  localparam int CNT_W  = 11;
  localparam int STS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BIG  = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLR,
    S_INIT_FIRST,
    S_INIT_CHK,
    S_FR_CHK,
    S_FR_TK,
    S_FR_DONE,
    S_MG_CHK,
    S_MG_TST,
    S_MG_LO,
    S_MG_UP,
    S_UNL1,
    S_UNL2,
    S_PUSH1,
    S_PUSH2,
    S_AL_CHK,
    S_AL_SCAN,
    S_AL_SPLIT,
    S_OUT
  } state_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INIT_START,
    CMD_CLR,
    CMD_INIT_FIRST,
    CMD_INIT_FREE,
    CMD_INIT_INC,
    CMD_RD_INFO_P,
    CMD_FR_MARK,
    CMD_RD_INFO_B,
    CMD_MG_HI,
    CMD_MG_LO,
    CMD_MG_UP,
    CMD_RD_LINK,
    CMD_UNLINK,
    CMD_PUSH1,
    CMD_PUSH2,
    CMD_AL_INIT,
    CMD_O_INC,
    CMD_AL_TAKE,
    CMD_SPLIT,
    CMD_AL_FIN,
    CMD_RES_ZERO,
    CMD_RES_BIG,
    CMD_RES_NONE
  } cmd_t;

  // Datapath status toward the controller
  typedef struct packed {
    op_t  op;
    logic pin_ok;
    logic clr_last;
    logic init_more;
    logic taken;
    logic o_top;
    logic b_ok;
    logic buddy_free;
    logic req_big;
    logic head_ok;
    logic o_gt_req;
    logic split_b_ok;
  } stat_t;

endpackage

FILE: rtl/core/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for the allocator: walks initialize, allocate and free through
// list unlink and push subroutines and drives one datapath command a cycle.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bpa_pkg::stat_t stat,
  output bpa_pkg::cmd_t  cmd
);

  bpa_pkg::state_t state_r, state_nxt;
  bpa_pkg::state_t ret_r, ret_nxt;
  logic            from_init_r, from_init_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_IDLE;
      ret_r       <= bpa_pkg::S_IDLE;
      from_init_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      from_init_r <= from_init_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    from_init_nxt = from_init_r;
    cmd           = bpa_pkg::CMD_NONE;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = bpa_pkg::CMD_ACCEPT;
          state_nxt = bpa_pkg::S_DISPATCH;
        end
      end
      bpa_pkg::S_DISPATCH: begin
        case (stat.op)
          bpa_pkg::OP_INIT: begin
            cmd       = bpa_pkg::CMD_INIT_START;
            state_nxt = bpa_pkg::S_CLR;
          end
          bpa_pkg::OP_ALLOC: state_nxt = bpa_pkg::S_AL_CHK;
          bpa_pkg::OP_FREE: begin
            from_init_nxt = 1'b0;
            state_nxt     = bpa_pkg::S_FR_CHK;
          end
          default: begin
            cmd       = bpa_pkg::CMD_RES_ZERO;
            state_nxt = bpa_pkg::S_OUT;
          end
        endcase
      end
      // Sweep every page back to taken at order zero
      bpa_pkg::S_CLR: begin
        cmd = bpa_pkg::CMD_CLR;
        if (stat.clr_last) state_nxt = bpa_pkg::S_INIT_FIRST;
      end
      bpa_pkg::S_INIT_FIRST: begin
        cmd       = bpa_pkg::CMD_INIT_FIRST;
        state_nxt = bpa_pkg::S_INIT_CHK;
      end
      bpa_pkg::S_INIT_CHK: begin
        if (stat.init_more) begin
          cmd           = bpa_pkg::CMD_INIT_FREE;
          from_init_nxt = 1'b1;
          state_nxt     = bpa_pkg::S_FR_CHK;
        end else begin
          cmd       = bpa_pkg::CMD_RES_ZERO;
          state_nxt = bpa_pkg::S_OUT;
        end
      end
      // Free one block, then merge upward
      bpa_pkg::S_FR_CHK: begin
        if (!from_init_r && !stat.pin_ok) begin
          state_nxt = bpa_pkg::S_FR_DONE;
        end else begin
          cmd       = bpa_pkg::CMD_RD_INFO_P;
          state_nxt = bpa_pkg::S_FR_TK;
        end
      end
      bpa_pkg::S_FR_TK: begin
        if (!stat.taken) begin
          state_nxt = bpa_pkg::S_FR_DONE;
        end else begin
          cmd       = bpa_pkg::CMD_FR_MARK;
          ret_nxt   = bpa_pkg::S_MG_CHK;
          state_nxt = bpa_pkg::S_PUSH1;
        end
      end
      bpa_pkg::S_FR_DONE: begin
        if (from_init_r) begin
          cmd       = bpa_pkg::CMD_INIT_INC;
          state_nxt = bpa_pkg::S_INIT_CHK;
        end else begin
          cmd       = bpa_pkg::CMD_RES_ZERO;
          state_nxt = bpa_pkg::S_OUT;
        end
      end
      bpa_pkg::S_MG_CHK: begin
        cmd = bpa_pkg::CMD_RD_INFO_B;
        if (stat.o_top || !stat.b_ok) state_nxt = bpa_pkg::S_FR_DONE;
        else                          state_nxt = bpa_pkg::S_MG_TST;
      end
      bpa_pkg::S_MG_TST: begin
        if (!stat.buddy_free) begin
          state_nxt = bpa_pkg::S_FR_DONE;
        end else begin
          cmd       = bpa_pkg::CMD_MG_HI;
          ret_nxt   = bpa_pkg::S_MG_LO;
          state_nxt = bpa_pkg::S_UNL1;
        end
      end
      bpa_pkg::S_MG_LO: begin
        cmd       = bpa_pkg::CMD_MG_LO;
        ret_nxt   = bpa_pkg::S_MG_UP;
        state_nxt = bpa_pkg::S_UNL1;
      end
      bpa_pkg::S_MG_UP: begin
        cmd       = bpa_pkg::CMD_MG_UP;
        ret_nxt   = bpa_pkg::S_MG_CHK;
        state_nxt = bpa_pkg::S_PUSH1;
      end
      // List subroutines
      bpa_pkg::S_UNL1: begin
        cmd       = bpa_pkg::CMD_RD_LINK;
        state_nxt = bpa_pkg::S_UNL2;
      end
      bpa_pkg::S_UNL2: begin
        cmd       = bpa_pkg::CMD_UNLINK;
        state_nxt = ret_r;
      end
      bpa_pkg::S_PUSH1: begin
        cmd       = bpa_pkg::CMD_PUSH1;
        state_nxt = bpa_pkg::S_PUSH2;
      end
      bpa_pkg::S_PUSH2: begin
        cmd       = bpa_pkg::CMD_PUSH2;
        state_nxt = ret_r;
      end
      // Allocate: scan orders, take head, split down
      bpa_pkg::S_AL_CHK: begin
        if (stat.req_big) begin
          cmd       = bpa_pkg::CMD_RES_BIG;
          state_nxt = bpa_pkg::S_OUT;
        end else begin
          cmd       = bpa_pkg::CMD_AL_INIT;
          state_nxt = bpa_pkg::S_AL_SCAN;
        end
      end
      bpa_pkg::S_AL_SCAN: begin
        if (stat.head_ok) begin
          cmd       = bpa_pkg::CMD_AL_TAKE;
          ret_nxt   = bpa_pkg::S_AL_SPLIT;
          state_nxt = bpa_pkg::S_UNL1;
        end else if (stat.o_top) begin
          cmd       = bpa_pkg::CMD_RES_NONE;
          state_nxt = bpa_pkg::S_OUT;
        end else begin
          cmd = bpa_pkg::CMD_O_INC;
        end
      end
      bpa_pkg::S_AL_SPLIT: begin
        if (stat.o_gt_req) begin
          cmd = bpa_pkg::CMD_SPLIT;
          if (stat.split_b_ok) begin
            ret_nxt   = bpa_pkg::S_AL_SPLIT;
            state_nxt = bpa_pkg::S_PUSH1;
          end
        end else begin
          cmd       = bpa_pkg::CMD_AL_FIN;
          state_nxt = bpa_pkg::S_OUT;
        end
      end
      bpa_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = bpa_pkg::S_IDLE;
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // One transaction in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result both open");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("accepted transaction not being processed");

  a_result_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (!out_valid && in_ready))
    else $error("result not retired after handshake");

endmodule

FILE: rtl/core/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Allocator datapath: page info and link memories, per-order list heads,
// running free page total, working registers and result registers.
// ----------------------------------------------------------------------------
module bpa_dp #(
  parameter int MAX_PAGES   = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpa_pkg::cmd_t                cmd,
  output bpa_pkg::stat_t               stat,
  input  logic                         cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]    cfg_page_count,
  input  logic [bpa_pkg::OP_W-1:0]     in_operation,
  input  logic [bpa_pkg::REQ_W-1:0]    in_order,
  input  logic [bpa_pkg::PIDX_W-1:0]   in_page_index,
  output logic [bpa_pkg::STS_W-1:0]    out_status,
  output logic [bpa_pkg::PIDX_W-1:0]   out_block_index,
  output logic [bpa_pkg::ORD_W-1:0]    out_block_order,
  output logic [bpa_pkg::CNT_W-1:0]    out_free_pages
);

  localparam int PW = $clog2(MAX_PAGES);
  localparam int LW = PW + 1;
  localparam int OB = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam int IW = bpa_pkg::ORD_W + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_PAGES);

  // Memories
  logic [IW-1:0] info_mem [MAX_PAGES];
  logic [LW-1:0] next_mem [MAX_PAGES];
  logic [LW-1:0] prev_mem [MAX_PAGES];
  logic [IW-1:0] info_q;
  logic [LW-1:0] next_q, prev_q;

  logic          info_we;
  logic [PW-1:0] info_wa, info_ra;
  logic [IW-1:0] info_wd;
  logic          next_we, prev_we;
  logic [PW-1:0] next_wa, prev_wa;
  logic [LW-1:0] next_wd, prev_wd;

  // Registers
  logic [bpa_pkg::CNT_W-1:0]  page_count_r;
  logic [LW-1:0]              pool_r, pool_nxt;
  logic [LW-1:0]              head_r [ORDER_COUNT];
  logic [LW-1:0]              head_nxt [ORDER_COUNT];
  logic [bpa_pkg::CNT_W-1:0]  free_r, free_nxt;
  logic [LW-1:0]              i_r, i_nxt;
  logic [PW-1:0]              p_r, p_nxt, b_r, b_nxt, node_r, node_nxt;
  logic [OB-1:0]              o_r, o_nxt;
  logic [bpa_pkg::REQ_W-1:0]  req_r, req_nxt;
  logic [bpa_pkg::OP_W-1:0]   op_r, op_nxt;
  logic                       pin_ok_r, pin_ok_nxt;
  logic [bpa_pkg::STS_W-1:0]  res_sts_r, res_sts_nxt;
  logic [bpa_pkg::PIDX_W-1:0] res_idx_r, res_idx_nxt;
  logic [bpa_pkg::ORD_W-1:0]  res_ord_r, res_ord_nxt;

  // Derived values
  logic [LW-1:0]             head_o;
  logic                      head_ok;
  logic [31:0]               buddy_w, split_w, pc_w;
  logic [OB-1:0]             o_dec;
  logic [PW-1:0]             lo, hi;
  logic [bpa_pkg::ORD_W-1:0] ord_q;
  logic [OB-1:0]             ord_cl;
  logic [bpa_pkg::CNT_W-1:0] pw2;
  logic                      pv_ok, n_ok;

  assign head_o  = head_r[o_r];
  assign head_ok = head_o < NIL;
  assign buddy_w = 32'(p_r) ^ (32'd1 << o_r);
  assign o_dec   = o_r - OB'(1);
  assign split_w = 32'(p_r) ^ (32'd1 << o_dec);
  assign lo      = (32'(p_r) < 32'(b_r)) ? p_r : b_r;
  assign hi      = (32'(p_r) < 32'(b_r)) ? b_r : p_r;
  assign ord_q   = info_q[bpa_pkg::ORD_W-1:0];
  assign ord_cl  = (32'(ord_q) >= 32'(ORDER_COUNT)) ? OB'(ORDER_COUNT - 1) : OB'(ord_q);
  assign pw2     = bpa_pkg::CNT_W'(1) << o_r;
  assign pv_ok   = prev_q < NIL;
  assign n_ok    = next_q < NIL;
  assign pc_w    = 32'(page_count_r);

  // Status toward the controller
  always_comb begin
    stat.op         = bpa_pkg::op_t'(op_r);
    stat.pin_ok     = pin_ok_r;
    stat.clr_last   = (i_r == LW'(MAX_PAGES - 1));
    stat.init_more  = (i_r < pool_r);
    stat.taken      = info_q[IW-1];
    stat.o_top      = (32'(o_r) == 32'(ORDER_COUNT - 1));
    stat.b_ok       = (buddy_w < 32'(pool_r));
    stat.buddy_free = !info_q[IW-1] && (32'(ord_q) == 32'(o_r));
    stat.req_big    = (32'(req_r) >= 32'(ORDER_COUNT));
    stat.head_ok    = head_ok;
    stat.o_gt_req   = (32'(o_r) > 32'(req_r));
    stat.split_b_ok = (split_w < 32'(pool_r));
  end

  // Command decode
  always_comb begin
    pool_nxt    = pool_r;
    head_nxt    = head_r;
    free_nxt    = free_r;
    i_nxt       = i_r;
    p_nxt       = p_r;
    b_nxt       = b_r;
    node_nxt    = node_r;
    o_nxt       = o_r;
    req_nxt     = req_r;
    op_nxt      = op_r;
    pin_ok_nxt  = pin_ok_r;
    res_sts_nxt = res_sts_r;
    res_idx_nxt = res_idx_r;
    res_ord_nxt = res_ord_r;
    info_we     = 1'b0;
    info_wa     = p_r;
    info_wd     = '0;
    info_ra     = p_r;
    next_we     = 1'b0;
    next_wa     = node_r;
    next_wd     = head_o;
    prev_we     = 1'b0;
    prev_wa     = node_r;
    prev_wd     = NIL;
    case (cmd)
      bpa_pkg::CMD_ACCEPT: begin
        op_nxt     = in_operation;
        req_nxt    = in_order;
        p_nxt      = PW'(32'(in_page_index));
        pin_ok_nxt = 32'(in_page_index) < 32'(pool_r);
      end
      bpa_pkg::CMD_INIT_START: begin
        pool_nxt = (pc_w > 32'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(pc_w);
        for (int k = 0; k < ORDER_COUNT; k++) head_nxt[k] = NIL;
        free_nxt = '0;
        i_nxt    = '0;
      end
      bpa_pkg::CMD_CLR: begin
        info_we = 1'b1;
        info_wa = i_r[PW-1:0];
        info_wd = {1'b1, bpa_pkg::ORD_W'(0)};
        i_nxt   = i_r + LW'(1);
      end
      bpa_pkg::CMD_INIT_FIRST: i_nxt = '0;
      bpa_pkg::CMD_INIT_FREE:  p_nxt = i_r[PW-1:0];
      bpa_pkg::CMD_INIT_INC:   i_nxt = i_r + LW'(1);
      bpa_pkg::CMD_RD_INFO_P:  info_ra = p_r;
      bpa_pkg::CMD_FR_MARK: begin
        o_nxt    = ord_cl;
        node_nxt = p_r;
        info_we  = 1'b1;
        info_wa  = p_r;
        info_wd  = {1'b0, bpa_pkg::ORD_W'(ord_cl)};
      end
      bpa_pkg::CMD_RD_INFO_B: begin
        info_ra = buddy_w[PW-1:0];
        b_nxt   = buddy_w[PW-1:0];
      end
      bpa_pkg::CMD_MG_HI: begin
        node_nxt = hi;
        info_we  = 1'b1;
        info_wa  = hi;
        info_wd  = {1'b1, bpa_pkg::ORD_W'(o_r)};
      end
      bpa_pkg::CMD_MG_LO: node_nxt = lo;
      bpa_pkg::CMD_MG_UP: begin
        o_nxt    = o_r + OB'(1);
        p_nxt    = lo;
        node_nxt = lo;
        info_we  = 1'b1;
        info_wa  = lo;
        info_wd  = {1'b0, bpa_pkg::ORD_W'(32'(o_r) + 32'd1)};
      end
      // Unlink node: link data was read the cycle before
      bpa_pkg::CMD_UNLINK: begin
        if (pv_ok) begin
          next_we = 1'b1;
          next_wa = prev_q[PW-1:0];
          next_wd = next_q;
        end else begin
          head_nxt[o_r] = next_q;
        end
        if (n_ok) begin
          prev_we = 1'b1;
          prev_wa = next_q[PW-1:0];
          prev_wd = prev_q;
        end
        free_nxt = free_r - pw2;
      end
      // Push node at head of list o
      bpa_pkg::CMD_PUSH1: begin
        next_we = 1'b1;
        next_wa = node_r;
        next_wd = head_o;
        prev_we = 1'b1;
        prev_wa = node_r;
        prev_wd = NIL;
      end
      bpa_pkg::CMD_PUSH2: begin
        if (head_ok) begin
          prev_we = 1'b1;
          prev_wa = head_o[PW-1:0];
          prev_wd = LW'(node_r);
        end
        head_nxt[o_r] = LW'(node_r);
        free_nxt      = free_r + pw2;
      end
      bpa_pkg::CMD_AL_INIT: o_nxt = OB'(req_r);
      bpa_pkg::CMD_O_INC:   o_nxt = o_r + OB'(1);
      bpa_pkg::CMD_AL_TAKE: begin
        p_nxt    = head_o[PW-1:0];
        node_nxt = head_o[PW-1:0];
      end
      bpa_pkg::CMD_SPLIT: begin
        o_nxt    = o_dec;
        node_nxt = split_w[PW-1:0];
        if (split_w < 32'(pool_r)) begin
          info_we = 1'b1;
          info_wa = split_w[PW-1:0];
          info_wd = {1'b0, bpa_pkg::ORD_W'(o_dec)};
        end
      end
      bpa_pkg::CMD_AL_FIN: begin
        info_we     = 1'b1;
        info_wa     = p_r;
        info_wd     = {1'b1, bpa_pkg::ORD_W'(req_r)};
        res_sts_nxt = bpa_pkg::ST_OK;
        res_idx_nxt = bpa_pkg::PIDX_W'(32'(p_r));
        res_ord_nxt = bpa_pkg::ORD_W'(req_r);
      end
      bpa_pkg::CMD_RES_ZERO: begin
        res_sts_nxt = bpa_pkg::ST_OK;
        res_idx_nxt = '0;
        res_ord_nxt = '0;
      end
      bpa_pkg::CMD_RES_BIG: begin
        res_sts_nxt = bpa_pkg::ST_BIG;
        res_idx_nxt = '0;
        res_ord_nxt = '0;
      end
      bpa_pkg::CMD_RES_NONE: begin
        res_sts_nxt = bpa_pkg::ST_NONE;
        res_idx_nxt = '0;
        res_ord_nxt = '0;
      end
      default: ;
    endcase
  end

  // Memory ports: one write, one registered read each
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[node_r];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_q <= prev_mem[node_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_count_r <= bpa_pkg::CNT_W'(1024);
      pool_r       <= '0;
      free_r       <= '0;
      for (int k = 0; k < ORDER_COUNT; k++) head_r[k] <= NIL;
    end else begin
      if (cfg_we) page_count_r <= cfg_page_count;
      pool_r <= pool_nxt;
      free_r <= free_nxt;
      for (int k = 0; k < ORDER_COUNT; k++) head_r[k] <= head_nxt[k];
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    p_r       <= p_nxt;
    b_r       <= b_nxt;
    node_r    <= node_nxt;
    o_r       <= o_nxt;
    req_r     <= req_nxt;
    op_r      <= op_nxt;
    pin_ok_r  <= pin_ok_nxt;
    res_sts_r <= res_sts_nxt;
    res_idx_r <= res_idx_nxt;
    res_ord_r <= res_ord_nxt;
  end

  assign out_status      = res_sts_r;
  assign out_block_index = res_idx_r;
  assign out_block_order = res_ord_r;
  assign out_free_pages  = free_r;

  // Pool never exceeds the page memory
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pool_r) <= 32'(MAX_PAGES))
    else $error("pool larger than page memory");

  // A push always lands the node at the head of its list
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bpa_pkg::CMD_PUSH2) |=> (head_r[$past(o_r)] == LW'($past(node_r))))
    else $error("push did not update list head");

  // Initialize starts from an empty free total
  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == bpa_pkg::CMD_INIT_START) |=> (free_r == '0))
    else $error("free total not cleared by initialize");

endmodule

FILE: rtl/core/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Buddy page allocator: initialize, allocate and free over a page pool with
// one doubly linked free list per order, reporting total free pages.
// ----------------------------------------------------------------------------
// One transaction at a time. Allocate scans orders upward, takes a list head and
//   splits down; free merges with free buddies upward; initialize sweeps all
//   MAX_PAGES pages back to taken, then frees each pool page in turn.
// Throughput is set by the sequencer stepping one-write one-read list memories
//   with registered reads. Reset empties the pool; no clearing pass runs at reset.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top #(
  parameter int MAX_PAGES   = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_page_count,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bpa_pkg::OP_W-1:0]   in_operation,
  input  logic [bpa_pkg::REQ_W-1:0]  in_order,
  input  logic [bpa_pkg::PIDX_W-1:0] in_page_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bpa_pkg::STS_W-1:0]  out_status,
  output logic [bpa_pkg::PIDX_W-1:0] out_block_index,
  output logic [bpa_pkg::ORD_W-1:0]  out_block_order,
  output logic [bpa_pkg::CNT_W-1:0]  out_free_pages
);

  bpa_pkg::cmd_t  cmd;
  bpa_pkg::stat_t stat;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Memories and registers
  bpa_dp #(
    .MAX_PAGES   (MAX_PAGES),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_page_count  (cfg_page_count),
    .in_operation    (in_operation),
    .in_order        (in_order),
    .in_page_index   (in_page_index),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_block_order (out_block_order),
    .out_free_pages  (out_free_pages)
  );

endmodule

FILE: tb/buddy_page_allocator_checker.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches the configuration port and both channels of the buddy page
// allocator, predicts every result from its own copy of the pool state and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker #(
  parameter int MAX_PAGES   = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]  cfg_page_count,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [bpa_pkg::OP_W-1:0]   in_operation,
  input  logic [bpa_pkg::REQ_W-1:0]  in_order,
  input  logic [bpa_pkg::PIDX_W-1:0] in_page_index,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [bpa_pkg::STS_W-1:0]  out_status,
  input  logic [bpa_pkg::PIDX_W-1:0] out_block_index,
  input  logic [bpa_pkg::ORD_W-1:0]  out_block_order,
  input  logic [bpa_pkg::CNT_W-1:0]  out_free_pages,
  output int                         err_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIL = MAX_PAGES;

  typedef struct packed {
    logic [bpa_pkg::STS_W-1:0]  status;
    logic [bpa_pkg::PIDX_W-1:0] block_index;
    logic [bpa_pkg::ORD_W-1:0]  block_order;
    logic [bpa_pkg::CNT_W-1:0]  free_pages;
  } alloc_result_t;

  // Shadow of the allocator state
  logic                      taken_bit  [MAX_PAGES];
  logic [bpa_pkg::ORD_W-1:0] page_ord   [MAX_PAGES];
  int                        next_link  [MAX_PAGES];
  int                        prev_link  [MAX_PAGES];
  int                        free_head  [ORDER_COUNT];
  logic [bpa_pkg::CNT_W-1:0] free_cnt   [ORDER_COUNT];
  logic [bpa_pkg::CNT_W-1:0] pool_cfg;
  int                        pool_size;

  alloc_result_t result_q[$];

  function automatic int clamp_ord(int o);
    return (o < ORDER_COUNT) ? o : ORDER_COUNT - 1;
  endfunction

  function automatic void list_push(int p, int o);
    o = clamp_ord(o);
    if (p >= MAX_PAGES) return;
    prev_link[p] = NIL;
    next_link[p] = free_head[o];
    if (free_head[o] < MAX_PAGES) prev_link[free_head[o]] = p;
    free_head[o] = p;
    free_cnt[o]  = free_cnt[o] + 1'b1;
  endfunction

  function automatic void list_unlink(int p, int o);
    int n;
    int pv;
    o = clamp_ord(o);
    if (p >= MAX_PAGES) return;
    n  = next_link[p];
    pv = prev_link[p];
    if (pv < MAX_PAGES) next_link[pv] = n;
    else free_head[o] = n;
    if (n < MAX_PAGES) prev_link[n] = pv;
    free_cnt[o] = free_cnt[o] - 1'b1;
  endfunction

  // Release a block and merge with free buddies up to the top order
  function automatic void release_block(int p);
    int o;
    int b;
    int lo;
    int hi;
    if (p >= pool_size || p >= MAX_PAGES || !taken_bit[p]) return;
    o = clamp_ord(int'(page_ord[p]));
    page_ord[p]  = bpa_pkg::ORD_W'(o);
    taken_bit[p] = 1'b0;
    list_push(p, o);
    while (o < ORDER_COUNT - 1) begin
      b = p ^ (1 << o);
      if (b >= pool_size || b >= MAX_PAGES) break;
      if (taken_bit[b] || int'(page_ord[b]) != o) break;
      lo = (p < b) ? p : b;
      hi = (p < b) ? b : p;
      taken_bit[hi] = 1'b1;
      list_unlink(hi, o);
      list_unlink(lo, o);
      o++;
      page_ord[lo] = bpa_pkg::ORD_W'(o);
      list_push(lo, o);
      p = lo;
    end
  endfunction

  function automatic void clear_lists();
    for (int i = 0; i < MAX_PAGES; i++) begin
      taken_bit[i] = 1'b1;
      page_ord[i]  = '0;
    end
    for (int i = 0; i < ORDER_COUNT; i++) begin
      free_head[i] = NIL;
      free_cnt[i]  = '0;
    end
  endfunction

  function automatic logic [bpa_pkg::CNT_W-1:0] free_total();
    logic [bpa_pkg::CNT_W-1:0] s;
    s = '0;
    for (int o = 0; o < ORDER_COUNT; o++) s = s + (free_cnt[o] << o);
    return s;
  endfunction

  // Apply one transaction to the shadow state and return its result
  function automatic alloc_result_t predict_op(logic [bpa_pkg::OP_W-1:0] op,
                                               logic [bpa_pkg::REQ_W-1:0] req,
                                               logic [bpa_pkg::PIDX_W-1:0] pidx);
    alloc_result_t r;
    int o;
    int p;
    int b;
    r = '0;
    case (op)
      bpa_pkg::OP_INIT: begin
        pool_size = (int'(pool_cfg) > MAX_PAGES) ? MAX_PAGES : int'(pool_cfg);
        clear_lists();
        for (int i = 0; i < pool_size; i++) release_block(i);
      end
      bpa_pkg::OP_ALLOC: begin
        if (int'(req) >= ORDER_COUNT) begin
          r.status = bpa_pkg::ST_BIG;
        end else begin
          o = int'(req);
          while (o < ORDER_COUNT && free_head[o] >= MAX_PAGES) o++;
          if (o >= ORDER_COUNT) begin
            r.status = bpa_pkg::ST_NONE;
          end else begin
            p = free_head[o];
            list_unlink(p, o);
            while (o > int'(req)) begin
              o--;
              b = p ^ (1 << o);
              if (b < pool_size && b < MAX_PAGES) begin
                taken_bit[b] = 1'b0;
                page_ord[b]  = bpa_pkg::ORD_W'(o);
                list_push(b, o);
              end
            end
            page_ord[p]   = bpa_pkg::ORD_W'(req);
            taken_bit[p]  = 1'b1;
            r.block_index = bpa_pkg::PIDX_W'(p);
            r.block_order = bpa_pkg::ORD_W'(req);
          end
        end
      end
      bpa_pkg::OP_FREE: release_block(int'(pidx));
      default: ;
    endcase
    r.free_pages = free_total();
    return r;
  endfunction

  // Track configuration, predict on input, compare on output
  always @(posedge clk) begin
    alloc_result_t exp_r;
    alloc_result_t got_r;
    if (!rst_n) begin
      clear_lists();
      for (int i = 0; i < MAX_PAGES; i++) begin
        next_link[i] = 0;
        prev_link[i] = 0;
      end
      pool_cfg  = 11'd1024;
      pool_size = 0;
      result_q.delete();
      err_count = 0;
    end else begin
      if (cfg_we) pool_cfg = cfg_page_count;
      if (out_valid && out_ready) begin
        got_r = {out_status, out_block_index, out_block_order, out_free_pages};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got_r);
          err_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (got_r.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_r.status, got_r.status);
            err_count++;
          end
          if (got_r.block_index !== exp_r.block_index) begin
            $display("%0t: block_index expected %0d actual %0d", $time,
                     exp_r.block_index, got_r.block_index);
            err_count++;
          end
          if (got_r.block_order !== exp_r.block_order) begin
            $display("%0t: block_order expected %0d actual %0d", $time,
                     exp_r.block_order, got_r.block_order);
            err_count++;
          end
          if (got_r.free_pages !== exp_r.free_pages) begin
            $display("%0t: free_pages expected %0d actual %0d", $time,
                     exp_r.free_pages, got_r.free_pages);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(predict_op(in_operation, in_order, in_page_index));
    end
    pending = result_q.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the buddy page allocator: directed corner cases, then phases
// of random allocate, free, initialize and unused-code traffic over several pool
// sizes, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bpa_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                       CYCLE_LIMIT = 3000000;
  localparam int                       PHASE_ITEMS = 190;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bpa_pkg::CNT_W-1:0]    cfg_page_count;
  logic                         in_valid;
  logic                         in_ready;
  logic [bpa_pkg::OP_W-1:0]     in_operation;
  logic [bpa_pkg::REQ_W-1:0]    in_order;
  logic [bpa_pkg::PIDX_W-1:0]   in_page_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [bpa_pkg::STS_W-1:0]    out_status;
  logic [bpa_pkg::PIDX_W-1:0]   out_block_index;
  logic [bpa_pkg::ORD_W-1:0]    out_block_order;
  logic [bpa_pkg::CNT_W-1:0]    out_free_pages;
  int                           err_count;
  int                           pending;
  int                           cycles;
  int                           sent;
  bit                           calm;
  bit                           stall_req;
  logic [bpa_pkg::OP_W-1:0]     sent_ops[$];
  int                           live_blocks[$];

  buddy_page_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_page_count(cfg_page_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_order(in_order), .in_page_index(in_page_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_block_index(out_block_index), .out_block_order(out_block_order),
    .out_free_pages(out_free_pages)
  );

  buddy_page_allocator_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_page_count(cfg_page_count),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_order(in_order), .in_page_index(in_page_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_block_index(out_block_index), .out_block_order(out_block_order),
    .out_free_pages(out_free_pages),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Output side: random backpressure plus one long requested hold
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Remember blocks handed out so frees target real allocations
  always @(posedge clk) begin
    logic [bpa_pkg::OP_W-1:0] op;
    if (rst_n && out_valid && out_ready && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (op == bpa_pkg::OP_INIT) live_blocks.delete();
      else if (op == bpa_pkg::OP_ALLOC && out_status == bpa_pkg::ST_OK)
        live_blocks.push_back(int'(out_block_index));
    end
    if (rst_n && in_valid && in_ready) sent_ops.push_back(in_operation);
  end

  // Offer one transaction and hold it until accepted
  task automatic send(logic [bpa_pkg::OP_W-1:0] op, logic [bpa_pkg::REQ_W-1:0] ord,
                      logic [bpa_pkg::PIDX_W-1:0] pidx);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_order      <= ord;
    in_page_index <= pidx;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drain, settle, then write the page count
  task automatic write_pages(logic [bpa_pkg::CNT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_page_count <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    int k;
    pick = $urandom_range(0, 199);
    if (pick < 1) begin
      send(bpa_pkg::OP_INIT, bpa_pkg::REQ_W'($urandom), bpa_pkg::PIDX_W'($urandom));
    end else if (pick < 7) begin
      send(OP_UNUSED, bpa_pkg::REQ_W'($urandom), bpa_pkg::PIDX_W'($urandom));
    end else if (pick < 12) begin
      send(bpa_pkg::OP_ALLOC, bpa_pkg::REQ_W'($urandom_range(11, 63)),
           bpa_pkg::PIDX_W'($urandom));
    end else if (pick < 20) begin
      send(bpa_pkg::OP_FREE, bpa_pkg::REQ_W'($urandom), bpa_pkg::PIDX_W'($urandom));
    end else if (pick < 105 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      send(bpa_pkg::OP_FREE, bpa_pkg::REQ_W'($urandom),
           bpa_pkg::PIDX_W'(live_blocks[k]));
      live_blocks.delete(k);
    end else begin
      send(bpa_pkg::OP_ALLOC,
           bpa_pkg::REQ_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                                       : $urandom_range(0, 3)),
           bpa_pkg::PIDX_W'($urandom));
    end
  endtask

  initial begin
    logic [bpa_pkg::CNT_W-1:0] sizes[6];
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_page_count = '0;
    in_valid       = 1'b0;
    in_operation   = bpa_pkg::OP_INIT;
    in_order       = '0;
    in_page_index  = '0;
    calm           = 1'b0;
    stall_req      = 1'b0;
    sent           = 0;
    sizes = '{11'd1024, 11'd1, 11'd37, 11'd2047, 11'd600, 11'd1000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on an empty pool before any initialize
    send(bpa_pkg::OP_ALLOC, 6'd0, '0);
    send(bpa_pkg::OP_FREE, '0, 10'd5);
    send(OP_UNUSED, 6'd63, 10'd1023);
    send(bpa_pkg::OP_ALLOC, 6'd63, '0);
    send(bpa_pkg::OP_ALLOC, 6'd11, '0);
    send(bpa_pkg::OP_ALLOC, 6'd10, '0);
    // Full pool at reset size: take and return whole blocks
    send(bpa_pkg::OP_INIT, '0, '0);
    send(bpa_pkg::OP_ALLOC, 6'd10, '0);
    send(bpa_pkg::OP_ALLOC, 6'd0, '0);
    send(bpa_pkg::OP_FREE, '0, '0);
    send(bpa_pkg::OP_ALLOC, 6'd0, '0);
    send(bpa_pkg::OP_ALLOC, 6'd5, '0);
    send(bpa_pkg::OP_FREE, '0, 10'd32);
    send(bpa_pkg::OP_FREE, '0, 10'd32);
    send(bpa_pkg::OP_FREE, '0, '0);
    // Free of a page inside a block, then rebuild
    send(bpa_pkg::OP_FREE, '0, 10'd1023);
    send(bpa_pkg::OP_ALLOC, 6'd0, '0);
    // Empty pool and an oversize count that clamps
    write_pages(11'd0);
    send(bpa_pkg::OP_INIT, '0, '0);
    send(bpa_pkg::OP_ALLOC, 6'd0, '0);
    send(bpa_pkg::OP_FREE, '0, '0);
    write_pages(11'd2047);
    send(bpa_pkg::OP_INIT, '0, '0);
    send(bpa_pkg::OP_FREE, '0, 10'd1000);

    // Random phases over several pool sizes
    for (int ph = 0; ph < 6; ph++) begin
      write_pages(sizes[ph]);
      send(bpa_pkg::OP_INIT, bpa_pkg::REQ_W'($urandom), bpa_pkg::PIDX_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm = (ph == 2);
        if (ph == 3 && i == 20) stall_req = 1'b1;
        random_item();
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
